FILE: rtl/core/spc_pkg.sv
`default_nettype none

package spc_pkg;

  // Pipeline depths of the iterative units
  localparam int SQRT_STAGES = 32;
  localparam int DIV_STAGES  = 31;

  // Q1.30 unity
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  typedef struct packed {
    logic signed [31:0] first_x;
    logic signed [31:0] first_y;
    logic signed [31:0] first_z;
    logic        [30:0] first_radius;
    logic signed [31:0] second_x;
    logic signed [31:0] second_y;
    logic signed [31:0] second_z;
    logic        [30:0] second_radius;
  } pair_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] normal_x;
    logic signed [31:0] normal_y;
    logic signed [31:0] normal_z;
    logic        [31:0] depth;
    logic signed [31:0] contact_x;
    logic signed [31:0] contact_y;
    logic signed [31:0] contact_z;
  } contact_t;

endpackage

`default_nettype wire

FILE: rtl/core/spc_isqrt.sv
`default_nettype none

// Floor square root of a 64 bit value, one result bit per stage.
module spc_isqrt
  import spc_pkg::*;
(
  input  logic        clk,
  input  logic        en,
  input  logic [63:0] value,
  output logic [31:0] root
);

  logic [63:0] num [SQRT_STAGES];
  logic [63:0] res [SQRT_STAGES];

  for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (2 * (SQRT_STAGES - 1 - k));
    logic [63:0] num_in;
    logic [63:0] res_in;
    logic [63:0] trial;

    if (k == 0) begin : g_first
      assign num_in = value;
      assign res_in = '0;
    end else begin : g_rest
      assign num_in = num[k-1];
      assign res_in = res[k-1];
    end

    assign trial = res_in + BIT;

    always_ff @(posedge clk) begin
      if (en) begin
        if (num_in >= trial) begin
          num[k] <= num_in - trial;
          res[k] <= (res_in >> 1) + BIT;
        end else begin
          num[k] <= num_in;
          res[k] <= res_in >> 1;
        end
      end
    end
  end

  assign root = res[SQRT_STAGES-1][31:0];

endmodule

`default_nettype wire

FILE: rtl/core/spc_div.sv
`default_nettype none

// Restoring divider, one quotient bit per stage. The quotient must fit in
// DIV_STAGES bits, so the top numerator bits start as the remainder.
module spc_div
  import spc_pkg::*;
(
  input  logic                   clk,
  input  logic                   en,
  input  logic [DIV_STAGES+30:0] numer,
  input  logic [31:0]            denom,
  output logic [DIV_STAGES-1:0]  quot
);

  logic [31:0]           rem [DIV_STAGES];
  logic [31:0]           den [DIV_STAGES];
  logic [DIV_STAGES-1:0] low [DIV_STAGES];
  logic [DIV_STAGES-1:0] q   [DIV_STAGES];

  for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
    logic [31:0]           rem_in;
    logic [31:0]           den_in;
    logic [DIV_STAGES-1:0] low_in;
    logic [DIV_STAGES-1:0] q_in;
    logic [32:0]           cand;
    logic                  take;

    if (k == 0) begin : g_first
      assign rem_in = 32'(numer[DIV_STAGES+30:DIV_STAGES]);
      assign den_in = denom;
      assign low_in = numer[DIV_STAGES-1:0];
      assign q_in   = '0;
    end else begin : g_rest
      assign rem_in = rem[k-1];
      assign den_in = den[k-1];
      assign low_in = low[k-1];
      assign q_in   = q[k-1];
    end

    assign cand = {rem_in, low_in[DIV_STAGES-1-k]};
    assign take = cand >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        rem[k] <= take ? 32'(cand - {1'b0, den_in}) : cand[31:0];
        den[k] <= den_in;
        low[k] <= low_in;
        q[k]   <= {q_in[DIV_STAGES-2:0], take};
      end
    end
  end

  assign quot = q[DIV_STAGES-1];

endmodule

`default_nettype wire

FILE: rtl/core/sphere_pair_contact.sv
`default_nettype none

// Sphere pair contact test, fully pipelined.
//
// Input channel (pair_valid / pair_stall / pair): one sphere pair per
// transfer, centres and radii in Q16.16. Output channel (contact_valid /
// contact_stall / contact): one contact record per pair, in order.
//
// From an input transfer to contact_valid a pair passes 8 stages of
// difference, square and prescale, 32 stages of the two square roots (one
// root bit per stage), one setup stage, 31 stages of the three normal
// dividers (one quotient bit per stage) and 5 stages of contact arithmetic.
// Throughput is one pair per cycle while the receiver does not stall; the
// root and divider pipelines set the depth.
//
// Reset clears every stage valid bit; payload registers are not reset.
// When the receiver stalls a waiting result the whole pipeline holds, and
// pair_stall rises until the result is taken; nothing is dropped.
module sphere_pair_contact
  import spc_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     pair_valid,
  output logic     pair_stall,
  input  pair_t    pair,
  output logic     contact_valid,
  input  logic     contact_stall,
  output contact_t contact
);

  typedef struct packed {
    logic [2:0][31:0]   p1;
    logic [2:0]         neg;
    logic signed [31:0] rd;
    logic [31:0]        rsum;
  } carry_t;

  typedef struct packed {
    logic             ovf;
    logic             zero;
    logic [2:0][30:0] e;
    carry_t           c;
  } side_a_t;

  typedef struct packed {
    logic               hit;
    logic               zero;
    logic [31:0]        depth;
    logic signed [33:0] t2;
    logic [2:0][31:0]   p1;
    logic [2:0]         neg;
  } side_b_t;

  // Shift that brings a nonzero value below 2^31 up into [2^30, 2^31)
  function automatic logic [4:0] lead_shift(input logic [30:0] v);
    logic [4:0] sh;
    sh = '0;
    for (int i = 0; i < 31; i++) begin
      if (v[i]) sh = 5'(30 - i);
    end
    return sh;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [34:0] v);
    logic [31:0] r;
    if (v > 35'sd2147483647) r = 32'h7FFF_FFFF;
    else if (v < -35'sd2147483648) r = 32'h8000_0000;
    else r = v[31:0];
    return r;
  endfunction

  logic adv;

  // Hold everything while a finished result waits
  assign adv        = !(contact_valid && contact_stall);
  assign pair_stall = !adv;

  logic [2:0][31:0] a_pos;
  logic [2:0][31:0] b_pos;

  assign a_pos = {pair.first_z, pair.first_y, pair.first_x};
  assign b_pos = {pair.second_z, pair.second_y, pair.second_x};

  // ---------------------------------------------------------------------
  // Front stages: differences, magnitudes, squares, prescale
  // ---------------------------------------------------------------------
  logic [8:1] v;

  logic [2:0][32:0] d1;
  logic [2:0][31:0] p1_1;
  logic [30:0]      r1_1;
  logic [30:0]      r2_1;

  logic [2:0][31:0] m2;
  carry_t           c2;

  logic [2:0][31:0] m3;
  logic [2:0][63:0] sq3;
  carry_t           c3;

  logic [65:0]      s_sum;
  logic [31:0]      mx_c;
  logic [2:0][31:0] m4;
  logic [63:0]      s4;
  logic             ovf4;
  logic [31:0]      mx4;
  carry_t           c4;

  logic [2:0][31:0] m5;
  logic [63:0]      s5;
  logic             ovf5;
  logic             right5;
  logic             zero5;
  logic [4:0]       sh5;
  carry_t           c5;

  logic [2:0][30:0] e6;
  logic [63:0]      s6;
  logic             ovf6;
  logic             zero6;
  carry_t           c6;

  logic [2:0][30:0] e7;
  logic [2:0][61:0] esq7;
  logic [63:0]      s7;
  logic             ovf7;
  logic             zero7;
  carry_t           c7;

  logic [2:0][30:0] e8;
  logic [63:0]      s8;
  logic [63:0]      ss8;
  logic             ovf8;
  logic             zero8;
  carry_t           c8;

  assign s_sum = {2'b00, sq3[0]} + {2'b00, sq3[1]} + {2'b00, sq3[2]};

  always_comb begin
    mx_c = m3[0];
    if (m3[1] > mx_c) mx_c = m3[1];
    if (m3[2] > mx_c) mx_c = m3[2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else if (adv) begin
      v <= {v[7:1], pair_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // stage 1: centre differences
      for (int i = 0; i < 3; i++) begin
        d1[i] <= {b_pos[i][31], b_pos[i]} - {a_pos[i][31], a_pos[i]};
      end
      p1_1 <= a_pos;
      r1_1 <= pair.first_radius;
      r2_1 <= pair.second_radius;

      // stage 2: magnitudes and radius sums
      for (int i = 0; i < 3; i++) begin
        m2[i]     <= d1[i][32] ? 32'(-d1[i]) : d1[i][31:0];
        c2.neg[i] <= d1[i][32];
      end
      c2.p1   <= p1_1;
      c2.rd   <= {1'b0, r1_1} - {1'b0, r2_1};
      c2.rsum <= {1'b0, r1_1} + {1'b0, r2_1};

      // stage 3: squares
      for (int i = 0; i < 3; i++) begin
        sq3[i] <= m2[i] * m2[i];
      end
      m3 <= m2;
      c3 <= c2;

      // stage 4: squared distance, largest component
      s4   <= s_sum[63:0];
      ovf4 <= |s_sum[65:64];
      mx4  <= mx_c;
      m4   <= m3;
      c4   <= c3;

      // stage 5: prescale decision
      right5 <= mx4[31];
      zero5  <= mx4 == '0;
      sh5    <= lead_shift(mx4[30:0]);
      m5     <= m4;
      s5     <= s4;
      ovf5   <= ovf4;
      c5     <= c4;

      // stage 6: prescaled components
      for (int i = 0; i < 3; i++) begin
        e6[i] <= right5 ? m5[i][31:1] : 31'(m5[i][30:0] << sh5);
      end
      s6    <= s5;
      ovf6  <= ovf5;
      zero6 <= zero5;
      c6    <= c5;

      // stage 7: prescaled squares
      for (int i = 0; i < 3; i++) begin
        esq7[i] <= e6[i] * e6[i];
      end
      e7    <= e6;
      s7    <= s6;
      ovf7  <= ovf6;
      zero7 <= zero6;
      c7    <= c6;

      // stage 8: prescaled squared length
      ss8   <= 64'(esq7[0]) + 64'(esq7[1]) + 64'(esq7[2]);
      e8    <= e7;
      s8    <= s7;
      ovf8  <= ovf7;
      zero8 <= zero7;
      c8    <= c7;
    end
  end

  // ---------------------------------------------------------------------
  // Square roots: centre distance and prescaled length side by side
  // ---------------------------------------------------------------------
  logic [31:0] centre_dist;
  logic [31:0] len;

  spc_isqrt u_dist_sqrt (
    .clk   (clk),
    .en    (adv),
    .value (s8),
    .root  (centre_dist)
  );

  spc_isqrt u_len_sqrt (
    .clk   (clk),
    .en    (adv),
    .value (ss8),
    .root  (len)
  );

  logic [SQRT_STAGES-1:0] va;
  side_a_t                sa [SQRT_STAGES];
  side_a_t                sa_in;
  side_a_t                sa_out;

  assign sa_in  = '{ovf: ovf8, zero: zero8, e: e8, c: c8};
  assign sa_out = sa[SQRT_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      va <= '0;
    end else if (adv) begin
      va <= {va[SQRT_STAGES-2:0], v[8]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sa[0] <= sa_in;
      for (int k = 1; k < SQRT_STAGES; k++) begin
        sa[k] <= sa[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Setup stage: hit test, depth, doubled contact distance, dividends
  // ---------------------------------------------------------------------
  logic                   pv;
  side_b_t                pb;
  logic [2:0][DIV_STAGES+30:0] numer_p;
  logic [31:0]            denom_p;

  always_ff @(posedge clk) begin
    if (rst) begin
      pv <= 1'b0;
    end else if (adv) begin
      pv <= va[SQRT_STAGES-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pb.hit   <= !sa_out.ovf && (centre_dist <= sa_out.c.rsum);
      pb.zero  <= sa_out.zero;
      pb.depth <= sa_out.c.rsum - centre_dist;
      // 2*r1 - depth folds to (r1 - r2) + distance
      pb.t2    <= {{2{sa_out.c.rd[31]}}, sa_out.c.rd} + {2'b00, centre_dist};
      pb.p1    <= sa_out.c.p1;
      pb.neg   <= sa_out.c.neg;
      for (int i = 0; i < 3; i++) begin
        numer_p[i] <= (DIV_STAGES+31)'({sa_out.e[i], 30'd0})
                    + (DIV_STAGES+31)'(len[31:1]);
      end
      // keep the divisor nonzero when the centres coincide
      denom_p <= sa_out.zero ? 32'd1 : len;
    end
  end

  // ---------------------------------------------------------------------
  // Normal dividers
  // ---------------------------------------------------------------------
  logic [2:0][DIV_STAGES-1:0] quot;

  for (genvar i = 0; i < 3; i++) begin : g_div
    spc_div u_div (
      .clk   (clk),
      .en    (adv),
      .numer (numer_p[i]),
      .denom (denom_p),
      .quot  (quot[i])
    );
  end

  logic [DIV_STAGES-1:0] vb;
  side_b_t               sb [DIV_STAGES];
  side_b_t               sb_out;

  assign sb_out = sb[DIV_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vb <= '0;
    end else if (adv) begin
      vb <= {vb[DIV_STAGES-2:0], pv};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb[0] <= pb;
      for (int k = 1; k < DIV_STAGES; k++) begin
        sb[k] <= sb[k-1];
      end
    end
  end

  // ---------------------------------------------------------------------
  // Tail stages: normal, contact offset, saturated contact point
  // ---------------------------------------------------------------------
  logic [4:1] qv;

  logic               hit_q1;
  logic [31:0]        depth_q1;
  logic [2:0][31:0]   p1_q1;
  logic [2:0]         neg_q1;
  logic               t2neg_q1;
  logic [32:0]        t2mag_q1;
  logic [2:0][30:0]   nm_q1;
  logic signed [33:0] t2_inv;

  logic               hit_q2;
  logic [31:0]        depth_q2;
  logic [2:0][31:0]   p1_q2;
  logic [2:0]         sign_q2;
  logic [2:0][63:0]   prod_q2;
  logic [2:0][31:0]   nrm_q2;

  logic               hit_q3;
  logic [31:0]        depth_q3;
  logic [2:0][31:0]   p1_q3;
  logic [2:0]         sign_q3;
  logic [2:0][32:0]   off_q3;
  logic [2:0][31:0]   nrm_q3;

  logic                     hit_q4;
  logic [31:0]              depth_q4;
  logic [2:0][31:0]         nrm_q4;
  logic signed [2:0][34:0]  pos_q4;

  contact_t contact_next;

  assign t2_inv = -sb_out.t2;

  always_ff @(posedge clk) begin
    if (rst) begin
      qv            <= '0;
      contact_valid <= 1'b0;
    end else if (adv) begin
      qv            <= {qv[3:1], vb[DIV_STAGES-1]};
      contact_valid <= qv[4];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // clamp the quotient, drop it for coincident centres
      hit_q1   <= sb_out.hit;
      depth_q1 <= sb_out.depth;
      p1_q1    <= sb_out.p1;
      neg_q1   <= sb_out.neg;
      t2neg_q1 <= sb_out.t2[33];
      t2mag_q1 <= sb_out.t2[33] ? t2_inv[32:0] : sb_out.t2[32:0];
      for (int i = 0; i < 3; i++) begin
        if (sb_out.zero) nm_q1[i] <= '0;
        else if (quot[i] > ONE_Q30) nm_q1[i] <= ONE_Q30;
        else nm_q1[i] <= quot[i];
      end

      // offset magnitude products and signed normal
      for (int i = 0; i < 3; i++) begin
        prod_q2[i] <= nm_q1[i] * t2mag_q1;
        nrm_q2[i]  <= neg_q1[i] ? -{1'b0, nm_q1[i]} : {1'b0, nm_q1[i]};
        sign_q2[i] <= neg_q1[i] ^ t2neg_q1;
      end
      hit_q2   <= hit_q1;
      depth_q2 <= depth_q1;
      p1_q2    <= p1_q1;

      // round half away from zero on the magnitude
      for (int i = 0; i < 3; i++) begin
        off_q3[i] <= 33'((prod_q2[i] + (64'd1 << 30)) >> 31);
      end
      sign_q3  <= sign_q2;
      nrm_q3   <= nrm_q2;
      hit_q3   <= hit_q2;
      depth_q3 <= depth_q2;
      p1_q3    <= p1_q2;

      // add the offset to the first centre
      for (int i = 0; i < 3; i++) begin
        if (sign_q3[i]) begin
          pos_q4[i] <= {{3{p1_q3[i][31]}}, p1_q3[i]} - {2'b00, off_q3[i]};
        end else begin
          pos_q4[i] <= {{3{p1_q3[i][31]}}, p1_q3[i]} + {2'b00, off_q3[i]};
        end
      end
      nrm_q4   <= nrm_q3;
      hit_q4   <= hit_q3;
      depth_q4 <= depth_q3;

      contact <= contact_next;
    end
  end

  // a miss carries nothing but the cleared hit flag
  always_comb begin
    contact_next = '0;
    if (hit_q4) begin
      contact_next.hit       = 1'b1;
      contact_next.normal_x  = nrm_q4[0];
      contact_next.normal_y  = nrm_q4[1];
      contact_next.normal_z  = nrm_q4[2];
      contact_next.depth     = depth_q4;
      contact_next.contact_x = sat32(pos_q4[0]);
      contact_next.contact_y = sat32(pos_q4[1]);
      contact_next.contact_z = sat32(pos_q4[2]);
    end
  end

endmodule

`default_nettype wire
